// ----- design/scrx_pkg.sv -----
// Package for the serial console receive FIFO device.
// Holds the action codes, bus register indexes and fixed result widths.
// No dependencies.
package scrx_pkg;

	typedef enum logic [1:0] {
		ACT_RX    = 2'd0,
		ACT_READ  = 2'd1,
		ACT_WRITE = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	localparam logic [1:0] REG_OUT_STATUS = 2'd0;
	localparam logic [1:0] REG_OUT_DATA   = 2'd1;
	localparam logic [1:0] REG_IN_STATUS  = 2'd2;
	localparam logic [1:0] REG_IN_DATA    = 2'd3;

	localparam logic [7:0] OUT_STATUS_VAL = 8'h00;
	localparam logic [7:0] OUT_DATA_VAL   = 8'hFF;
	localparam logic [7:0] IN_READY_VAL   = 8'h01;

	localparam int LEVEL_W            = 5;
	localparam int FIFO_DEPTH_DEFAULT = 16;

endpackage

// ----- design/scrx_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the receive byte storage. No dependencies.
module scrx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/serial_console_rx_fifo_device_core.sv -----
// Serial console with a receive FIFO: one result per accepted transfer.
// A result is presented the cycle after its transfer; a pop of a held byte
// is presented only after the synchronous read of the byte storage.
// One transfer per cycle, unless a result is held by out_stall or a pop read is pending.
// Reset clears the pointers, the fill count and the handshake flags at once;
// the byte storage is not cleared, since only written entries are ever read.
module serial_console_rx_fifo_device_core
	import scrx_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [1:0]   action,
	input  logic [1:0]   reg_index,
	input  logic [7:0]   data_in,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [7:0]   read_data,
	output logic         tx_valid,
	output logic [7:0]   tx_byte,
	output logic         irq,
	output logic [LEVEL_W-1:0] fifo_level,
	output logic         overflow
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

	logic [PTR_W-1:0] rd_ptr_q, wr_ptr_q;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             pend_q;
	logic             out_valid_q;
	logic [7:0]       read_data_q, tx_byte_q;
	logic             tx_valid_q, irq_q, overflow_q;
	logic [LEVEL_W-1:0] level_q;

	action_t    act;
	logic       accept, full, empty, push, pop, clr, drop;
	logic [7:0] rd_imm;
	logic [7:0] ram_rdata;
	logic [CNT_W+LEVEL_W-1:0] level_ext;

	assign act      = action_t'(action);
	assign in_stall = pend_q | (out_valid_q & out_stall);
	assign accept   = in_valid & ~in_stall;
	assign full     = (cnt_q == CNT_FULL);
	assign empty    = (cnt_q == '0);

	always_comb begin
		push   = 1'b0;
		pop    = 1'b0;
		clr    = 1'b0;
		drop   = 1'b0;
		rd_imm = 8'h00;
		if (accept) begin
			unique case (act)
				ACT_RX: begin
					push = ~full;
					drop = full;
				end
				ACT_READ: begin
					unique case (reg_index)
						REG_OUT_STATUS: rd_imm = OUT_STATUS_VAL;
						REG_OUT_DATA:   rd_imm = OUT_DATA_VAL;
						REG_IN_STATUS:  rd_imm = empty ? 8'h00 : IN_READY_VAL;
						REG_IN_DATA:    pop = ~empty;
					endcase
				end
				ACT_WRITE: ;
				ACT_CLEAR: clr = 1'b1;
			endcase
		end
	end

	always_comb begin
		priority if (clr) begin
			cnt_d = '0;
		end else if (push) begin
			cnt_d = cnt_q + CNT_W'(1);
		end else if (pop) begin
			cnt_d = cnt_q - CNT_W'(1);
		end else begin
			cnt_d = cnt_q;
		end
	end

	assign level_ext = {{LEVEL_W{1'b0}}, cnt_d};

	// A write lands at the edge before any later read samples the array, so a
	// pop right after a push of the same entry sees the new byte.
	scrx_ram #(
		.WIDTH(8),
		.DEPTH(FIFO_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (push),
		.waddr(wr_ptr_q),
		.wdata(data_in),
		.re   (pop),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			pend_q <= pop;
			if (clr) begin
				rd_ptr_q <= '0;
				wr_ptr_q <= '0;
			end else begin
				if (push) begin
					wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
				end
				if (pop) begin
					rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
				end
			end
			if (accept) begin
				out_valid_q <= ~pop;
			end else if (pend_q) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The result fields are loaded at the transfer; a popped byte is loaded
	// afterwards from the storage read port, while pend_q is set.
	always_ff @(posedge clk) begin
		if (accept) begin
			read_data_q <= rd_imm;
			tx_valid_q  <= (act == ACT_WRITE) && (reg_index == REG_OUT_DATA);
			tx_byte_q   <= ((act == ACT_WRITE) && (reg_index == REG_OUT_DATA)) ?
				data_in : 8'h00;
			irq_q       <= (cnt_d != '0);
			level_q     <= level_ext[LEVEL_W-1:0];
			overflow_q  <= drop;
		end else if (pend_q) begin
			read_data_q <= ram_rdata;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;
	assign tx_valid   = tx_valid_q;
	assign tx_byte    = tx_byte_q;
	assign irq        = irq_q;
	assign fifo_level = level_q;
	assign overflow   = overflow_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("fill count exceeds FIFO depth");

	a_pend_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> in_stall && !out_valid_q)
		else $error("transfer possible while a pop read is pending");

	a_pend_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |=> out_valid_q)
		else $error("pending pop did not present its result");

	a_pop_pends: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> pend_q && $past(cnt_q) != '0)
		else $error("pop did not start a storage read");
`endif

endmodule
